// ----- sv/pdlf_pkg.sv -----
// ----------------------------------------------------------------------------
// pdlf_pkg
// Shared types, microcode codes and constants of the PD line follower drive.
// ----------------------------------------------------------------------------
`default_nettype none

package pdlf_pkg;

  // Fixed field widths
  localparam int ELAPSED_W     = 16;
  localparam int SPEED_W       = 7;
  localparam int GAIN_W        = 8;
  localparam int WIDTH_W       = 7;
  localparam int OUT_W         = 16;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 8;

  // Arithmetic constants
  localparam int KD_FRAC_BITS  = 4;
  localparam int US_PER_S      = 1000000;
  localparam int CMD_LIMIT     = 100;
  localparam int PWM_PERIOD    = 100;
  localparam int MB_W          = 21;   // wide enough for one million, signed

  // Divider: eight quotient bits, top bit flags saturation
  localparam int QUO_W         = 8;
  localparam int CNT_W         = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_GAIN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_GAIN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 8'd3;

  // Register reset values
  localparam logic [SPEED_W-1:0] RST_BASE_SPEED = 7'd40;
  localparam logic [GAIN_W-1:0]  RST_RIGHT_GAIN = 8'd72;
  localparam logic [GAIN_W-1:0]  RST_LEFT_GAIN  = 8'd72;
  localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN = 8'd24;

  // Program counter
  localparam int                PC_W      = 5;
  localparam logic [PC_W-1:0]   PC_START  = 5'd0;
  localparam logic [PC_W-1:0]   LAST_STEP = 5'd18;

  // Datapath operations
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_MUL_BASE = 4'd2;
  localparam logic [3:0] OP_SET_BASE = 4'd3;
  localparam logic [3:0] OP_MUL_RG   = 4'd4;
  localparam logic [3:0] OP_MUL_LG   = 4'd5;
  localparam logic [3:0] OP_MUL_KD   = 4'd6;
  localparam logic [3:0] OP_MUL_EL   = 4'd7;
  localparam logic [3:0] OP_MUL_US   = 4'd8;
  localparam logic [3:0] OP_ADD_R    = 4'd9;
  localparam logic [3:0] OP_SUB_L    = 4'd10;
  localparam logic [3:0] OP_ADD_D    = 4'd11;
  localparam logic [3:0] OP_DIV_INIT = 4'd12;
  localparam logic [3:0] OP_DIV_STEP = 4'd13;
  localparam logic [3:0] OP_DIV_END  = 4'd14;

  // Sequencer jump kinds
  localparam logic [2:0] J_NEXT     = 3'd0;  // fall through
  localparam logic [2:0] J_WAIT_IN  = 3'd1;  // hold until an input item arrives
  localparam logic [2:0] J_WAIT_OUT = 3'd2;  // hold until output is free, then jump
  localparam logic [2:0] J_LOOP     = 3'd3;  // jump while the loop count runs
  localparam logic [2:0] J_GOTO     = 3'd4;  // always jump

  // Wheel select
  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  // One microcode word
  typedef struct packed {
    logic [3:0]      op;
    logic            side;
    logic            emit;
    logic [2:0]      jmp;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic loop_more;
  } status_t;

  // One result item
  typedef struct packed {
    logic               right_reverse;
    logic [WIDTH_W-1:0] right_width;
    logic               left_reverse;
    logic [WIDTH_W-1:0] left_width;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/pd_line_follower_drive.sv -----
// ----------------------------------------------------------------------------
// pd_line_follower_drive
// PD line follower: two sensor readings to sign-magnitude PWM for two wheels.
// ----------------------------------------------------------------------------
// Each input item runs the 19 program steps, two of them 8-step restoring
// divide loops; the next input item is taken only when the program is back
// at its start step. A result held at the output stalls the last step and
// the next item with it.
// Reset: clears the step counter, the output valid flag and the stored error,
// and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pd_line_follower_drive #(
  parameter int SENSOR_BITS = 12
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Input items: left_sensor, right_sensor, elapsed_us (lowest bits first)
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  input  wire logic [((2*SENSOR_BITS+16+7)/8)*8-1:0] s_axis_tdata,
  // Result items: left_width, left_reverse, right_width, right_reverse
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output      logic [pdlf_pkg::OUT_W-1:0]         m_axis_tdata,
  // Configuration writes
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [pdlf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pdlf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic [pdlf_pkg::PC_W-1:0]       pc_q, pc_d;
  logic [pdlf_pkg::SPEED_W-1:0]    base_speed_q;
  logic [pdlf_pkg::GAIN_W-1:0]     right_gain_q;
  logic [pdlf_pkg::GAIN_W-1:0]     left_gain_q;
  logic [pdlf_pkg::GAIN_W-1:0]     deriv_gain_q;
  logic                            out_valid_q;
  pdlf_pkg::result_t               out_q;

  pdlf_pkg::ctrl_t                 ctrl;
  pdlf_pkg::ctrl_t                 ctrl_exec;
  pdlf_pkg::status_t               status;
  pdlf_pkg::result_t               result;
  logic                            out_busy;
  logic                            stall;
  logic                            take;

  // Fetch the control word
  pdlf_rom u_rom (
    .pc_i   (pc_q),
    .ctrl_o (ctrl)
  );

  // Hold and jump decisions
  assign out_busy = out_valid_q && !m_axis_tready;
  assign stall    = ((ctrl.jmp == pdlf_pkg::J_WAIT_IN)  && !s_axis_tvalid) ||
                    ((ctrl.jmp == pdlf_pkg::J_WAIT_OUT) && out_busy);
  assign take     = (ctrl.jmp == pdlf_pkg::J_GOTO) ||
                    (ctrl.jmp == pdlf_pkg::J_WAIT_OUT) ||
                    ((ctrl.jmp == pdlf_pkg::J_LOOP) && status.loop_more);

  always_comb begin
    ctrl_exec = ctrl;
    if (stall) begin
      ctrl_exec.op   = pdlf_pkg::OP_NOP;
      ctrl_exec.emit = 1'b0;
    end
  end

  always_comb begin
    if (stall) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= pdlf_pkg::PC_START;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign s_axis_tready = (pc_q == pdlf_pkg::PC_START);

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q <= pdlf_pkg::RST_BASE_SPEED;
      right_gain_q <= pdlf_pkg::RST_RIGHT_GAIN;
      left_gain_q  <= pdlf_pkg::RST_LEFT_GAIN;
      deriv_gain_q <= pdlf_pkg::RST_DERIV_GAIN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pdlf_pkg::REG_BASE_SPEED: base_speed_q <= cfg_data_i[pdlf_pkg::SPEED_W-1:0];
        pdlf_pkg::REG_RIGHT_GAIN: right_gain_q <= cfg_data_i;
        pdlf_pkg::REG_LEFT_GAIN:  left_gain_q  <= cfg_data_i;
        pdlf_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Datapath
  pdlf_datapath #(
    .SENSOR_BITS (SENSOR_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl_exec),
    .left_sensor_i  (s_axis_tdata[SENSOR_BITS-1:0]),
    .right_sensor_i (s_axis_tdata[2*SENSOR_BITS-1:SENSOR_BITS]),
    .elapsed_us_i   (s_axis_tdata[2*SENSOR_BITS+pdlf_pkg::ELAPSED_W-1:2*SENSOR_BITS]),
    .base_speed_i   (base_speed_q),
    .right_gain_i   (right_gain_q),
    .left_gain_i    (left_gain_q),
    .deriv_gain_i   (deriv_gain_q),
    .status_o       (status),
    .result_o       (result)
  );

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_exec.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_exec.emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Checks
  a_accept_starts_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (pc_q == pdlf_pkg::PC_START + 1'b1))
    else $error("input item taken but program did not advance");

  a_emit_returns_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> (pc_q == pdlf_pkg::PC_START))
    else $error("result raised without returning to the start step");

  a_width_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((out_q.left_width <= pdlf_pkg::WIDTH_W'(pdlf_pkg::PWM_PERIOD)) &&
                       (out_q.right_width <= pdlf_pkg::WIDTH_W'(pdlf_pkg::PWM_PERIOD))))
    else $error("pulse width beyond period");

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= pdlf_pkg::LAST_STEP)
    else $error("step counter left the program");

endmodule

`default_nettype wire

// ----- sv/pdlf_rom.sv -----
// ----------------------------------------------------------------------------
// pdlf_rom
// Microcode table: one control word per program step.
// ----------------------------------------------------------------------------
`default_nettype none

module pdlf_rom (
  input  wire logic [pdlf_pkg::PC_W-1:0] pc_i,
  output pdlf_pkg::ctrl_t                ctrl_o
);

  function automatic pdlf_pkg::ctrl_t uw(
    input logic [3:0]                op,
    input logic                      side,
    input logic                      emit,
    input logic [2:0]                jmp,
    input logic [pdlf_pkg::PC_W-1:0] target
  );
    pdlf_pkg::ctrl_t w;
    w.op     = op;
    w.side   = side;
    w.emit   = emit;
    w.jmp    = jmp;
    w.target = target;
    return w;
  endfunction

  // Program: load, build both numerators, then divide left and right
  always_comb begin
    case (pc_i)
      5'd0:  ctrl_o = uw(pdlf_pkg::OP_LOAD, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_WAIT_IN, 5'd0);
      5'd1:  ctrl_o = uw(pdlf_pkg::OP_MUL_BASE, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd2:  ctrl_o = uw(pdlf_pkg::OP_SET_BASE, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd3:  ctrl_o = uw(pdlf_pkg::OP_MUL_RG, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd4:  ctrl_o = uw(pdlf_pkg::OP_MUL_EL, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd5:  ctrl_o = uw(pdlf_pkg::OP_ADD_R, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd6:  ctrl_o = uw(pdlf_pkg::OP_MUL_LG, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd7:  ctrl_o = uw(pdlf_pkg::OP_MUL_EL, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd8:  ctrl_o = uw(pdlf_pkg::OP_SUB_L, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd9:  ctrl_o = uw(pdlf_pkg::OP_MUL_KD, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd10: ctrl_o = uw(pdlf_pkg::OP_MUL_US, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd11: ctrl_o = uw(pdlf_pkg::OP_ADD_D, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd12: ctrl_o = uw(pdlf_pkg::OP_DIV_INIT, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd13: ctrl_o = uw(pdlf_pkg::OP_DIV_STEP, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_LOOP, 5'd13);
      5'd14: ctrl_o = uw(pdlf_pkg::OP_DIV_END, pdlf_pkg::SIDE_LEFT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd15: ctrl_o = uw(pdlf_pkg::OP_DIV_INIT, pdlf_pkg::SIDE_RIGHT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd16: ctrl_o = uw(pdlf_pkg::OP_DIV_STEP, pdlf_pkg::SIDE_RIGHT, 1'b0,
                         pdlf_pkg::J_LOOP, 5'd16);
      5'd17: ctrl_o = uw(pdlf_pkg::OP_DIV_END, pdlf_pkg::SIDE_RIGHT, 1'b0,
                         pdlf_pkg::J_NEXT, 5'd0);
      5'd18: ctrl_o = uw(pdlf_pkg::OP_NOP, pdlf_pkg::SIDE_LEFT, 1'b1,
                         pdlf_pkg::J_WAIT_OUT, pdlf_pkg::PC_START);
      default: ctrl_o = uw(pdlf_pkg::OP_NOP, pdlf_pkg::SIDE_LEFT, 1'b0,
                           pdlf_pkg::J_GOTO, pdlf_pkg::PC_START);
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/pdlf_datapath.sv -----
// ----------------------------------------------------------------------------
// pdlf_datapath
// Shared multiplier, numerator accumulators and restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module pdlf_datapath #(
  parameter int SENSOR_BITS = 12
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pdlf_pkg::ctrl_t                   ctrl_i,
  input  wire logic [SENSOR_BITS-1:0]            left_sensor_i,
  input  wire logic [SENSOR_BITS-1:0]            right_sensor_i,
  input  wire logic [pdlf_pkg::ELAPSED_W-1:0]    elapsed_us_i,
  input  wire logic [pdlf_pkg::SPEED_W-1:0]      base_speed_i,
  input  wire logic [pdlf_pkg::GAIN_W-1:0]       right_gain_i,
  input  wire logic [pdlf_pkg::GAIN_W-1:0]       left_gain_i,
  input  wire logic [pdlf_pkg::GAIN_W-1:0]       deriv_gain_i,
  output pdlf_pkg::status_t                      status_o,
  output pdlf_pkg::result_t                      result_o
);

  localparam int E_W   = SENSOR_BITS + 1;
  localparam int D_W   = SENSOR_BITS + 2;
  localparam int MA_W  = SENSOR_BITS + 11;
  localparam int NUM_W = SENSOR_BITS + 32;
  localparam int SH    = SENSOR_BITS + pdlf_pkg::KD_FRAC_BITS;

  logic signed [E_W-1:0]                last_err_q;
  logic signed [E_W-1:0]                e_q;
  logic signed [D_W-1:0]                diff_q;
  logic [pdlf_pkg::ELAPSED_W-1:0]       el_q;
  logic [NUM_W-1:0]                     den_q;
  logic signed [NUM_W-1:0]              prod_q;
  logic signed [NUM_W-1:0]              numl_q;
  logic signed [NUM_W-1:0]              numr_q;
  logic [NUM_W-1:0]                     rem_q;
  logic [pdlf_pkg::QUO_W-1:0]           quo_q;
  logic                                 neg_q;
  logic [pdlf_pkg::CNT_W-1:0]           cnt_q;
  pdlf_pkg::result_t                    res_q;

  logic signed [E_W-1:0]                e_new;
  logic signed [MA_W-1:0]               mul_a;
  logic signed [pdlf_pkg::MB_W-1:0]     mul_b;
  logic signed [NUM_W-1:0]              mul_p;
  logic signed [NUM_W-1:0]              div_src;
  logic [NUM_W-1:0]                     trial;
  logic                                 sat;
  logic [pdlf_pkg::WIDTH_W-1:0]         mag;
  logic [pdlf_pkg::WIDTH_W-1:0]         pwm_w;
  logic                                 pwm_r;
  logic signed [pdlf_pkg::MB_W-1:0]     el_s;

  // Error of the incoming sample
  assign e_new = $signed({1'b0, left_sensor_i}) - $signed({1'b0, right_sensor_i});
  assign el_s  = pdlf_pkg::MB_W'($signed({1'b0, el_q}));

  // Operand select for the shared multiplier
  always_comb begin
    case (ctrl_i.op)
      pdlf_pkg::OP_MUL_BASE: begin
        mul_a = MA_W'($signed({1'b0, base_speed_i}));
        mul_b = el_s;
      end
      pdlf_pkg::OP_MUL_RG: begin
        mul_a = MA_W'(e_q);
        mul_b = pdlf_pkg::MB_W'($signed({1'b0, right_gain_i}));
      end
      pdlf_pkg::OP_MUL_LG: begin
        mul_a = MA_W'(e_q);
        mul_b = pdlf_pkg::MB_W'($signed({1'b0, left_gain_i}));
      end
      pdlf_pkg::OP_MUL_KD: begin
        mul_a = MA_W'(diff_q);
        mul_b = pdlf_pkg::MB_W'($signed({1'b0, deriv_gain_i}));
      end
      pdlf_pkg::OP_MUL_EL: begin
        mul_a = $signed(prod_q[MA_W-1:0]);
        mul_b = el_s;
      end
      pdlf_pkg::OP_MUL_US: begin
        mul_a = $signed(prod_q[MA_W-1:0]);
        mul_b = pdlf_pkg::MB_W'(pdlf_pkg::US_PER_S);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Divider source and trial subtrahend
  assign div_src = (ctrl_i.side == pdlf_pkg::SIDE_RIGHT) ? numr_q : numl_q;
  assign trial   = den_q << cnt_q;

  // Clamp and map to sign-magnitude PWM
  assign sat   = quo_q[pdlf_pkg::QUO_W-1] ||
                 (quo_q[pdlf_pkg::WIDTH_W-1:0] > pdlf_pkg::WIDTH_W'(pdlf_pkg::CMD_LIMIT));
  assign mag   = sat ? pdlf_pkg::WIDTH_W'(pdlf_pkg::CMD_LIMIT)
                     : quo_q[pdlf_pkg::WIDTH_W-1:0];
  assign pwm_r = neg_q && (mag != '0);
  assign pwm_w = pwm_r ? (pdlf_pkg::WIDTH_W'(pdlf_pkg::PWM_PERIOD) - mag) : mag;

  // Stored error and loop counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      cnt_q      <= '0;
    end else begin
      case (ctrl_i.op)
        pdlf_pkg::OP_LOAD:     last_err_q <= e_new;
        pdlf_pkg::OP_DIV_INIT: cnt_q      <= '1;
        pdlf_pkg::OP_DIV_STEP: cnt_q      <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      pdlf_pkg::OP_LOAD: begin
        e_q    <= e_new;
        diff_q <= D_W'(e_new) - D_W'(last_err_q);
        el_q   <= (elapsed_us_i == '0) ? pdlf_pkg::ELAPSED_W'(1) : elapsed_us_i;
      end
      pdlf_pkg::OP_MUL_BASE, pdlf_pkg::OP_MUL_RG, pdlf_pkg::OP_MUL_LG,
      pdlf_pkg::OP_MUL_KD, pdlf_pkg::OP_MUL_EL, pdlf_pkg::OP_MUL_US: begin
        prod_q <= mul_p;
      end
      pdlf_pkg::OP_SET_BASE: begin
        numl_q <= prod_q <<< SH;
        numr_q <= prod_q <<< SH;
        den_q  <= NUM_W'(el_q) << SH;
      end
      pdlf_pkg::OP_ADD_R: numr_q <= numr_q + (prod_q <<< pdlf_pkg::KD_FRAC_BITS);
      pdlf_pkg::OP_SUB_L: numl_q <= numl_q - (prod_q <<< pdlf_pkg::KD_FRAC_BITS);
      pdlf_pkg::OP_ADD_D: begin
        numr_q <= numr_q + prod_q;
        numl_q <= numl_q - prod_q;
      end
      pdlf_pkg::OP_DIV_INIT: begin
        neg_q <= div_src[NUM_W-1];
        rem_q <= div_src[NUM_W-1] ? $unsigned(-div_src) : $unsigned(div_src);
        quo_q <= '0;
      end
      pdlf_pkg::OP_DIV_STEP: begin
        if (rem_q >= trial) begin
          rem_q        <= rem_q - trial;
          quo_q[cnt_q] <= 1'b1;
        end
      end
      pdlf_pkg::OP_DIV_END: begin
        if (ctrl_i.side == pdlf_pkg::SIDE_RIGHT) begin
          res_q.right_width   <= pwm_w;
          res_q.right_reverse <= pwm_r;
        end else begin
          res_q.left_width    <= pwm_w;
          res_q.left_reverse  <= pwm_r;
        end
      end
      default: ;
    endcase
  end

  assign status_o.loop_more = (cnt_q != '0);
  assign result_o           = res_q;

endmodule

`default_nettype wire

// ----- bench/pdlf_drive_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pdlf_drive_checker
// Scoreboard for the PD line follower drive. It watches the sample stream, the
// configuration writes and the result stream, and computes each wheel command
// from its own copy of the gains and the previous error. It then compares
// every result item field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------

module pdlf_drive_checker
  import pdlf_pkg::*;
#(
  parameter int SENSOR_BITS = 12
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // Sample items: left_sensor, right_sensor, elapsed_us (lowest bits first)
  input  logic                                     s_axis_tvalid,
  input  logic                                     s_axis_tready,
  input  logic [((2*SENSOR_BITS+16+7)/8)*8-1:0]    s_axis_tdata,
  // Result items: left_width, left_reverse, right_width, right_reverse
  input  logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  input  logic [OUT_W-1:0]                         m_axis_tdata,
  // Configuration writes
  input  logic                                     cfg_valid_i,
  input  logic                                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                    cfg_data_i,
  output int                                       fail_count_o,
  output int                                       pending_o
);

  // Shadow copy of the configuration and the control state
  logic [SPEED_W-1:0] base_speed_q;
  logic [GAIN_W-1:0]  right_gain_q;
  logic [GAIN_W-1:0]  left_gain_q;
  logic [GAIN_W-1:0]  kd_q4_q;
  longint             prev_error;
  result_t            drive_q[$];
  int                 results_seen;

  // Log one failure and count it
  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_error($sformatf("result %0d %s: got %0d, expected %0d",
                             results_seen, name, got, want));
    end
  endtask

  // Truncated command, clamped, then folded into sign-magnitude PWM
  function automatic logic [7:0] pwm_of(input longint num, input longint den);
    longint cmd;
    cmd = num / den;
    if (cmd > CMD_LIMIT) cmd = CMD_LIMIT;
    if (cmd < -CMD_LIMIT) cmd = -CMD_LIMIT;
    if (cmd >= 0) return {1'b0, cmd[6:0]};
    cmd = cmd + PWM_PERIOD;
    return {1'b1, cmd[6:0]};
  endfunction

  // Both wheel commands over one common denominator: 2^(SENSOR_BITS+4) * elapsed
  function automatic result_t predict_drive(
    input  logic [SENSOR_BITS-1:0] left_in,
    input  logic [SENSOR_BITS-1:0] right_in,
    input  logic [ELAPSED_W-1:0]   elapsed_in,
    input  longint                 prev,
    output longint                 err
  );
    longint     lv, rv, el, diff, den;
    longint     g_base, g_r, g_l, g_d;
    longint     base_n, p_r, p_l, d_n;
    logic [7:0] lw, rw;
    result_t    res;
    lv = left_in;
    rv = right_in;
    el = elapsed_in;
    // a zero period counts as one microsecond
    if (el == 0) el = 1;
    g_base = base_speed_q;
    g_r = right_gain_q;
    g_l = left_gain_q;
    g_d = kd_q4_q;
    err = lv - rv;
    diff = err - prev;
    den = el << (SENSOR_BITS + KD_FRAC_BITS);
    base_n = g_base * den;
    p_r = (g_r * err * el) << KD_FRAC_BITS;
    p_l = (g_l * err * el) << KD_FRAC_BITS;
    d_n = g_d * diff * US_PER_S;
    lw = pwm_of(base_n - p_l - d_n, den);
    rw = pwm_of(base_n + p_r + d_n, den);
    res.left_width = lw[WIDTH_W-1:0];
    res.left_reverse = lw[7];
    res.right_width = rw[WIDTH_W-1:0];
    res.right_reverse = rw[7];
    return res;
  endfunction

  // Track handshakes on all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    longint  err;
    if (!rst_ni) begin
      base_speed_q = RST_BASE_SPEED;
      right_gain_q = RST_RIGHT_GAIN;
      left_gain_q = RST_LEFT_GAIN;
      kd_q4_q = RST_DERIV_GAIN;
      prev_error = 0;
      results_seen = 0;
      drive_q.delete();
      pending_o = 0;
    end else begin
      // compare a delivered result with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (drive_q.size() == 0) begin
          report_error($sformatf("result item %h arrived with none pending", m_axis_tdata));
        end else begin
          want = drive_q.pop_front();
          check_field("left_width", got.left_width, want.left_width);
          check_field("left_reverse", got.left_reverse, want.left_reverse);
          check_field("right_width", got.right_width, want.right_width);
          check_field("right_reverse", got.right_reverse, want.right_reverse);
        end
        results_seen++;
      end
      // predict the result of an accepted sample and advance the error
      if (s_axis_tvalid && s_axis_tready) begin
        drive_q.push_back(predict_drive(
          s_axis_tdata[SENSOR_BITS-1:0],
          s_axis_tdata[2*SENSOR_BITS-1:SENSOR_BITS],
          s_axis_tdata[2*SENSOR_BITS+ELAPSED_W-1:2*SENSOR_BITS],
          prev_error, err));
        prev_error = err;
      end
      // follow register writes; other indexes leave everything as is
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_BASE_SPEED: base_speed_q = cfg_data_i[SPEED_W-1:0];
          REG_RIGHT_GAIN: right_gain_q = cfg_data_i;
          REG_LEFT_GAIN:  left_gain_q = cfg_data_i;
          REG_DERIV_GAIN: kd_q4_q = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = drive_q.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for the PD line follower drive. A directed set of sensor samples
// comes first, then phases of random samples under several gain settings,
// with random gaps on the sample side and random stalls on the result side.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------

module tb;
  import pdlf_pkg::*;

  localparam int SENSOR_BITS  = 12;
  localparam int IN_W         = ((2*SENSOR_BITS+16+7)/8)*8;
  localparam int SENSOR_MAX   = (1 << SENSOR_BITS) - 1;
  localparam int ELAPSED_MAX  = (1 << ELAPSED_W) - 1;
  localparam int IDX_MAX      = (1 << CFG_IDX_W) - 1;
  localparam int DATA_MAX     = (1 << CFG_DATA_W) - 1;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 210;
  localparam int QUIET_PHASE  = 4;
  localparam int IDLE_PCT     = 33;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int                    fail_count;
  int                    pending;
  int                    cycle_cnt = 0;
  bit                    no_idle = 1'b0;

  pd_line_follower_drive #(.SENSOR_BITS(SENSOR_BITS)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pdlf_drive_checker #(.SENSOR_BITS(SENSOR_BITS)) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // 12 ns clock
  always #6 clk_i = ~clk_i;

  // Stall the result side at random, except in the quiet phase
  always @(negedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("pd_line_follower_drive regression: fail");
      $finish;
    end
  end

  // Offer one sample after a random gap; valid stays high for the next item
  task automatic send_sample(input int left_s,
                             input int right_s,
                             input int elapsed);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= IN_W'({$urandom, $urandom});
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_W'({ELAPSED_W'(elapsed), SENSOR_BITS'(right_s), SENSOR_BITS'(left_s)});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Load all four registers, framed by writes to indexes that do not exist
  task automatic program_gains(input logic [CFG_DATA_W-1:0] base,
                               input logic [CFG_DATA_W-1:0] kp_r,
                               input logic [CFG_DATA_W-1:0] kp_l,
                               input logic [CFG_DATA_W-1:0] kd);
    write_reg(CFG_IDX_W'($urandom_range(REG_DERIV_GAIN + 1, IDX_MAX)),
              CFG_DATA_W'($urandom_range(0, DATA_MAX)));
    write_reg(REG_BASE_SPEED, base);
    write_reg(REG_RIGHT_GAIN, kp_r);
    write_reg(REG_LEFT_GAIN, kp_l);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(CFG_IDX_W'($urandom_range(REG_DERIV_GAIN + 1, IDX_MAX)),
              CFG_DATA_W'($urandom_range(0, DATA_MAX)));
  endtask

  // Drop valid and hold until every result has come back
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int kind;
    int lsense;
    int rsense;
    int el;
    lsense = SENSOR_MAX / 2;
    rsense = SENSOR_MAX / 2;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed samples under the reset gains; the first takes its
    // derivative from a zero previous error
    send_sample(0, 0, 1);
    send_sample(SENSOR_MAX, 0, 1);
    send_sample(0, SENSOR_MAX, ELAPSED_MAX);
    send_sample(0, SENSOR_MAX, 0);
    send_sample(SENSOR_MAX, 0, 0);
    send_sample(SENSOR_MAX, SENSOR_MAX, ELAPSED_MAX);
    send_sample(2048, 2048, ELAPSED_MAX);
    send_sample(2100, 2000, ELAPSED_MAX);
    send_sample(2000, 2100, ELAPSED_MAX);
    send_sample(0, 0, ELAPSED_MAX);
    send_sample(SENSOR_MAX, 0, ELAPSED_MAX);
    send_sample(SENSOR_MAX, 0, ELAPSED_MAX);
    // left command just below zero truncates to forward, width zero
    send_sample(2276, 0, ELAPSED_MAX);
    send_sample(2276, 0, ELAPSED_MAX);
    // same for the right wheel
    send_sample(0, 2276, ELAPSED_MAX);
    send_sample(0, 2276, ELAPSED_MAX);
    send_sample('h555, 'hAAA, 'h5555);
    send_sample('hAAA, 'h555, 'hAAAA);
    send_sample(1, 0, 'h8000);
    send_sample(0, 1, 1);
    send_sample(SENSOR_MAX, SENSOR_MAX - 1, 'h7FFF);
    settle();

    // Random phases, each under its own gain setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: ;
        1: program_gains(8'd0, 8'd0, 8'd0, 8'd0);
        2: program_gains(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        3: program_gains(8'd100, 8'd255, 8'd0, 8'd0);
        4: program_gains(8'd0, 8'd1, 8'd1, 8'd255);
        default: program_gains(CFG_DATA_W'($urandom_range(0, DATA_MAX)),
                               CFG_DATA_W'($urandom_range(0, DATA_MAX)),
                               CFG_DATA_W'($urandom_range(0, DATA_MAX)),
                               CFG_DATA_W'($urandom_range(0, DATA_MAX)));
      endcase
      no_idle = (ph == QUIET_PHASE);
      repeat (PHASE_ITEMS) begin
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          // near the line: small error over a long sample period
          lsense = $urandom_range(0, SENSOR_MAX);
          rsense = lsense + $urandom_range(0, 600) - 300;
          el = $urandom_range(500, ELAPSED_MAX);
        end else if (kind < 60) begin
          // drift slowly from the previous sample
          lsense = lsense + $urandom_range(0, 80) - 40;
          rsense = rsense + $urandom_range(0, 80) - 40;
          el = $urandom_range(200, ELAPSED_MAX);
        end else if (kind < 80) begin
          lsense = $urandom_range(0, SENSOR_MAX);
          rsense = $urandom_range(0, SENSOR_MAX);
          el = $urandom_range(0, ELAPSED_MAX);
        end else if (kind < 90) begin
          // rails of the sensors and of the period
          lsense = $urandom_range(0, 1) ? SENSOR_MAX : 0;
          rsense = $urandom_range(0, 1) ? SENSOR_MAX : 0;
          case ($urandom_range(0, 2))
            0: el = 0;
            1: el = 1;
            default: el = ELAPSED_MAX;
          endcase
        end else begin
          // short periods blow up the derivative
          lsense = $urandom_range(0, SENSOR_MAX);
          rsense = $urandom_range(0, SENSOR_MAX);
          el = $urandom_range(1, 64);
        end
        if (lsense < 0) lsense = 0;
        if (lsense > SENSOR_MAX) lsense = SENSOR_MAX;
        if (rsense < 0) rsense = 0;
        if (rsense > SENSOR_MAX) rsense = SENSOR_MAX;
        send_sample(lsense, rsense, el);
      end
      settle();
      no_idle = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("pd_line_follower_drive regression: pass");
    end else begin
      $display("pd_line_follower_drive regression: fail");
    end
    $finish;
  end

endmodule
